// ----- rtl/urib_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// urib_pkg
// Shared types and constants for the UART register and interrupt block.
// ----------------------------------------------------------------------------
package urib_pkg;

  // Action codes of a request transaction.
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_RX     = 2'd2;

  // Register word index (byte offset divided by four).
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_IER    = 3'd1;
  localparam logic [2:0] REG_IIR    = 3'd2;
  localparam logic [2:0] REG_LCR    = 3'd3;
  localparam logic [2:0] REG_MCR    = 3'd4;
  localparam logic [2:0] REG_LSR    = 3'd5;
  localparam logic [2:0] REG_MSR    = 3'd6;
  localparam logic [2:0] REG_DIV    = 3'd7;

  // Access error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RD_WO    = 2'd1;
  localparam logic [1:0] ERR_WR_RO    = 2'd2;

  // Interrupt identity codes.
  localparam logic [2:0] IID_MODEM    = 3'd0;
  localparam logic [2:0] IID_NONE     = 3'd1;
  localparam logic [2:0] IID_THRE     = 3'd2;
  localparam logic [2:0] IID_RDA      = 3'd4;
  localparam logic [2:0] IID_LINE     = 3'd6;

  // Interrupt enable bit positions.
  localparam int IER_RDA   = 0;
  localparam int IER_THRE  = 1;
  localparam int IER_LINE  = 2;
  localparam int IER_MODEM = 3;

  localparam logic [7:0] LSR_TX_EMPTY_BITS = 8'h60;
  localparam logic [7:0] MODEM_CHANGE_MASK = 8'h0f;
  localparam logic [7:0] MODEM_STATUS      = 8'h00;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  byte_offset;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } urib_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic [1:0]  access_error;
    logic        rx_ready;
  } urib_result_t;

endpackage
`default_nettype wire

// ----- rtl/urib_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// urib_ifs
// Valid/ready channels for requests and results of the UART register block.
// ----------------------------------------------------------------------------
interface urib_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  byte_offset;
  logic [31:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, action, byte_offset, write_data, rx_byte, input ready);
  modport sink   (input valid, action, byte_offset, write_data, rx_byte, output ready);
endinterface

interface urib_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq;
  logic [1:0]  access_error;
  logic        rx_ready;

  modport source (output valid, read_data, tx_valid, tx_byte, irq, access_error, rx_ready,
                  input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq, access_error, rx_ready,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/uart_register_interrupt_block_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_register_interrupt_block_core
// Register side of a simple UART with priority interrupt identity.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one transaction per bus read, bus write or
//   received byte. Every request produces exactly one transaction on the
//   rsp channel with the read value, an optional transmit byte, the
//   interrupt line level, an access error code and the receive-ready flag.
//   The register state is updated in the same cycle the request is taken,
//   and the result lands in the output register, or in the skid register
//   if that one is full and not taken. The block takes one request
//   per cycle; the only limit on rate is the result side.
//   When the receiver stalls, one further result is parked in a skid
//   register, so a request is still taken while a finished result waits.
//   Request ready drops only while both the output and skid registers are
//   full, and comes back in the cycle after the receiver takes a result.
//   A synchronous reset clears the holding register, data-ready, the
//   sticky overrun flag, the interrupt enables and the interrupt identity,
//   and empties the output and skid registers.
// ----------------------------------------------------------------------------
module uart_register_interrupt_block_core
  import urib_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  urib_req_if.sink  req,
  urib_rsp_if.source rsp
);

  urib_item_t   item;
  urib_result_t new_result;
  logic         accept;
  logic         take;

  // Output register and the skid register behind it.
  logic         out_valid;
  urib_result_t out_res;
  logic         skid_valid;
  urib_result_t skid_res;

  assign item.action      = req.action;
  assign item.byte_offset = req.byte_offset;
  assign item.write_data  = req.write_data;
  assign item.rx_byte     = req.rx_byte;

  // Requests are refused only when the skid register is occupied.
  assign req.ready = ~skid_valid;
  assign accept    = req.valid & req.ready;
  assign take      = out_valid & rsp.ready;

  urib_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (new_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        // The skid register is empty whenever a request is accepted.
        if (!out_valid || take) begin
          out_valid <= 1'b1;
          out_res   <= new_result;
        end else begin
          skid_valid <= 1'b1;
          skid_res   <= new_result;
        end
      end else if (take) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = out_res.read_data;
  assign rsp.tx_valid     = out_res.tx_valid;
  assign rsp.tx_byte      = out_res.tx_byte;
  assign rsp.irq          = out_res.irq;
  assign rsp.access_error = out_res.access_error;
  assign rsp.rx_ready     = out_res.rx_ready;

endmodule
`default_nettype wire

// ----- rtl/urib_regfile.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// urib_regfile
// Receive holding register, status flags, enables and interrupt identity.
// ----------------------------------------------------------------------------
module urib_regfile
  import urib_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire urib_item_t   item,
  output urib_result_t      result
);

  logic [7:0] rx_holding, rx_holding_next;
  logic       data_ready, data_ready_next;
  logic       overrun_flag, overrun_flag_next;
  logic [3:0] irq_enables, irq_enables_next;
  logic [2:0] interrupt_identity, interrupt_identity_next;

  logic [2:0] word;
  logic       recompute;
  logic [2:0] iid_new;
  logic       modem_pending;

  assign word          = item.byte_offset[4:2];
  assign modem_pending = |(MODEM_STATUS & MODEM_CHANGE_MASK);

  // Priority encoder, evaluated on the updated flags and enables.
  always_comb begin
    if (overrun_flag_next && irq_enables_next[IER_LINE]) begin
      iid_new = IID_LINE;
    end else if (data_ready_next && irq_enables_next[IER_RDA]) begin
      iid_new = IID_RDA;
    end else if (irq_enables_next[IER_THRE]) begin
      iid_new = IID_THRE;
    end else if (modem_pending && irq_enables_next[IER_MODEM]) begin
      iid_new = IID_MODEM;
    end else begin
      iid_new = IID_NONE;
    end
  end

  always_comb begin
    rx_holding_next   = rx_holding;
    data_ready_next   = data_ready;
    overrun_flag_next = overrun_flag;
    irq_enables_next  = irq_enables;
    recompute         = 1'b0;
    result            = '0;

    case (item.action)
      ACT_READ: begin
        case (word)
          REG_DATA: begin
            result.read_data = {24'd0, rx_holding};
            data_ready_next  = 1'b0;
            recompute        = 1'b1;
          end
          REG_IIR: result.read_data = {29'd0, interrupt_identity};
          REG_LSR: result.read_data = {24'd0, LSR_TX_EMPTY_BITS | {6'd0, overrun_flag, data_ready}};
          REG_MSR: result.read_data = {24'd0, MODEM_STATUS};
          default: result.access_error = ERR_RD_WO;
        endcase
      end
      ACT_WRITE: begin
        recompute = 1'b1;
        case (word)
          REG_DATA: begin
            result.tx_valid = 1'b1;
            result.tx_byte  = item.write_data[7:0];
          end
          REG_IER: irq_enables_next = item.write_data[3:0];
          REG_IIR, REG_LSR, REG_MSR: result.access_error = ERR_WR_RO;
          default: ;
        endcase
      end
      ACT_RX: begin
        recompute         = 1'b1;
        overrun_flag_next = overrun_flag | data_ready;
        data_ready_next   = 1'b1;
        rx_holding_next   = item.rx_byte;
      end
      default: ;
    endcase

    interrupt_identity_next = recompute ? iid_new : interrupt_identity;
    result.irq = (interrupt_identity_next == IID_THRE) || (interrupt_identity_next == IID_RDA)
              || (interrupt_identity_next == IID_LINE);
    result.rx_ready = ~data_ready_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_holding         <= '0;
      data_ready         <= 1'b0;
      overrun_flag       <= 1'b0;
      irq_enables        <= '0;
      interrupt_identity <= '0;
    end else if (accept) begin
      rx_holding         <= rx_holding_next;
      data_ready         <= data_ready_next;
      overrun_flag       <= overrun_flag_next;
      irq_enables        <= irq_enables_next;
      interrupt_identity <= interrupt_identity_next;
    end
  end

endmodule
`default_nettype wire

// ----- dv/urib_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// urib_tb_pkg
// Response scoreboard for the UART register and interrupt block: it tracks
// the register state per request and checks every response field by field.
// ----------------------------------------------------------------------------
package urib_tb_pkg;
  import urib_pkg::*;

  // The action code that the block treats as a no-op.
  localparam logic [1:0] ACT_IDLE = 2'd3;

  class uart_reg_scoreboard;
    logic [7:0]   hold_byte;
    logic         data_ready;
    logic         overrun;
    logic [3:0]   enables;
    logic [2:0]   identity;
    urib_result_t expected_rsp[$];
    int unsigned  failures;

    function new();
      hold_byte  = '0;
      data_ready = 1'b0;
      overrun    = 1'b0;
      enables    = '0;
      identity   = IID_MODEM;
      failures   = 0;
    endfunction

    function void recompute_identity();
      if (overrun && enables[IER_LINE]) begin
        identity = IID_LINE;
      end else if (data_ready && enables[IER_RDA]) begin
        identity = IID_RDA;
      end else if (enables[IER_THRE]) begin
        identity = IID_THRE;
      end else if (((MODEM_STATUS & MODEM_CHANGE_MASK) != 8'h00) && enables[IER_MODEM]) begin
        identity = IID_MODEM;
      end else begin
        identity = IID_NONE;
      end
    endfunction

    function urib_result_t predict_response(urib_item_t req);
      urib_result_t rsp;
      logic [2:0]   word;
      rsp  = '0;
      word = req.byte_offset[4:2];
      case (req.action)
        ACT_READ: begin
          case (word)
            REG_DATA: begin
              rsp.read_data = {24'd0, hold_byte};
              data_ready = 1'b0;
              recompute_identity();
            end
            REG_IIR: rsp.read_data = {29'd0, identity};
            REG_LSR: rsp.read_data = {24'd0, LSR_TX_EMPTY_BITS | {6'd0, overrun, data_ready}};
            REG_MSR: rsp.read_data = {24'd0, MODEM_STATUS};
            default: rsp.access_error = ERR_RD_WO;
          endcase
        end
        ACT_WRITE: begin
          case (word)
            REG_DATA: begin
              rsp.tx_valid = 1'b1;
              rsp.tx_byte  = req.write_data[7:0];
            end
            REG_IER: enables = req.write_data[3:0];
            REG_IIR, REG_LSR, REG_MSR: rsp.access_error = ERR_WR_RO;
            default: ;
          endcase
          recompute_identity();
        end
        ACT_RX: begin
          if (data_ready) overrun = 1'b1;
          data_ready = 1'b1;
          hold_byte  = req.rx_byte;
          recompute_identity();
        end
        default: ;
      endcase
      rsp.irq      = (identity == IID_THRE) || (identity == IID_RDA) || (identity == IID_LINE);
      rsp.rx_ready = ~data_ready;
      return rsp;
    endfunction

    function void note_request(urib_item_t req);
      expected_rsp.push_back(predict_response(req));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got, realtime stamp);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", stamp, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(urib_result_t got, realtime stamp);
      urib_result_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t ns: unexpected response, expected none, actual 0x%0h", stamp, got);
        failures++;
        return;
      end
      want = expected_rsp.pop_front();
      report("read_data",    want.read_data,    got.read_data,    stamp);
      report("tx_valid",     want.tx_valid,     got.tx_valid,     stamp);
      report("tx_byte",      want.tx_byte,      got.tx_byte,      stamp);
      report("irq",          want.irq,          got.irq,          stamp);
      report("access_error", want.access_error, got.access_error, stamp);
      report("rx_ready",     want.rx_ready,     got.rx_ready,     stamp);
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UART register and interrupt block. A directed opening
// walks every register in both directions, the receive and overrun path and
// the interrupt priorities; a long random run follows. Both channels idle at
// random, and one long receiver hold-off fills the block so it stalls input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import urib_pkg::*;
  import urib_tb_pkg::*;

  // Number of random requests after the directed opening.
  localparam int RANDOM_REQUESTS = 1500;
  // Cycles without any transaction on either channel before the run is
  // declared hung. The longest legal quiet spell is the receiver hold-off.
  localparam int STALL_LIMIT     = 1000;
  // Receiver hold-off window and a window with no receiver stalls at all,
  // both counted in cycles after reset.
  localparam int HOLD_START      = 400;
  localparam int HOLD_CYCLES     = 150;
  localparam int CLEAN_START     = 1500;
  localparam int CLEAN_END       = 2100;

  logic clk;
  logic rst;

  urib_req_if req_ch();
  urib_rsp_if rsp_ch();

  uart_register_interrupt_block_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  uart_reg_scoreboard sb = new();
  int unsigned quiet_cycles;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Build one request from its fields.
  function automatic urib_item_t make_request(logic [1:0] action, logic [4:0] offset,
                                              logic [31:0] wdata, logic [7:0] rxb);
    urib_item_t req;
    req.action      = action;
    req.byte_offset = offset;
    req.write_data  = wdata;
    req.rx_byte     = rxb;
    return req;
  endfunction

  // Random request. Most traffic lands on the registers that matter for the
  // receive and interrupt paths (data, enables, identity, line status) so the
  // identity keeps moving; the rest hits any offset. Any request may also
  // carry the unused action code.
  function automatic urib_item_t random_request();
    int unsigned  pick;
    logic [2:0]   word;
    logic [1:0]   action;
    pick = $urandom_range(99);
    if (pick < 25) begin
      action = ACT_RX;
    end else if (pick < 70) begin
      action = ACT_READ;
    end else if (pick < 95) begin
      action = ACT_WRITE;
    end else begin
      action = ACT_IDLE;
    end
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(3))
        0: word = REG_DATA;
        1: word = REG_IER;
        2: word = REG_IIR;
        default: word = REG_LSR;
      endcase
    end else begin
      word = 3'($urandom_range(7));
    end
    return make_request(action, {word, 2'($urandom_range(3))}, $urandom,
                        8'($urandom_range(255)));
  endfunction

  // Offer one request at the falling edge and hold it until it is taken.
  // The task starts and ends at a falling edge; valid stays high between
  // back-to-back transactions.
  task automatic send_request(input urib_item_t req, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 35) begin
        req_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid       = 1'b1;
    req_ch.action      = req.action;
    req_ch.byte_offset = req.byte_offset;
    req_ch.write_data  = req.write_data;
    req_ch.rx_byte     = req.rx_byte;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(req);
    @(negedge clk);
  endtask

  // Directed opening: reads of every word at reset (identity still reads the
  // unrecomputed reset value), write-only reads and read-only writes with
  // odd byte lanes, transmit of extreme bytes, the interrupt priority ladder
  // from transmit-empty through receive to line error, overrun, and the
  // unused action code.
  task automatic run_directed();
    send_request(make_request(ACT_READ,  {REG_IIR, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_LSR, 2'd1}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_MSR, 2'd2}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_DATA, 2'd3}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_IER, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_LCR, 2'd3}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_MCR, 2'd1}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_DIV, 2'd3}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_DATA, 2'd0}, 32'hffff_ffff, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_DATA, 2'd2}, 32'd0, 8'hff), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_IER, 2'd0}, 32'hffff_ffff, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_IIR, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_RX,    5'd31, 32'hffff_ffff, 8'hff), 1'b0);
    send_request(make_request(ACT_READ,  {REG_IIR, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_RX,    5'd0, 32'd0, 8'h00), 1'b0);
    send_request(make_request(ACT_READ,  {REG_LSR, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_IIR, 2'd3}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_READ,  {REG_DATA, 2'd0}, 32'd0, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_IIR, 2'd1}, 32'hffff_ffff, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_LSR, 2'd2}, 32'h0000_00ff, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_MSR, 2'd3}, 32'h0000_000f, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_LCR, 2'd0}, 32'h8000_0001, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_MCR, 2'd0}, 32'h5555_aaaa, 8'd0), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_DIV, 2'd0}, 32'haaaa_5555, 8'd0), 1'b0);
    send_request(make_request(ACT_IDLE,  5'd31, 32'hffff_ffff, 8'hff), 1'b0);
    send_request(make_request(ACT_WRITE, {REG_IER, 2'd0}, 32'hffff_fff0, 8'd0), 1'b0);
  endtask

  // Stimulus: reset, directed opening, random run, then drain.
  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_READ;
    req_ch.byte_offset = '0;
    req_ch.write_data  = '0;
    req_ch.rx_byte     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // A stretch in the middle runs back to back with no sender gaps.
      send_request(random_request(), !(i >= 600 && i < 900));
    end
    req_ch.valid = 1'b0;

    // Everything is in; wait for the last responses, then keep running
    // so a stray extra transaction would still be caught.
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: stalls at random, except for one long hold-off that lets the
  // block fill up and stall its request side, and one window with no stalls.
  initial begin
    int unsigned cycle;
    rsp_ch.ready = 1'b0;
    cycle = 0;
    @(negedge clk iff !rst);
    forever begin
      if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES) begin
        rsp_ch.ready = 1'b0;
      end else if (cycle >= CLEAN_START && cycle < CLEAN_END) begin
        rsp_ch.ready = 1'b1;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= 35);
      end
      cycle++;
      @(negedge clk);
    end
  end

  // Response monitor: values are taken at the rising edge, before the block
  // updates its registers, and go to the scoreboard in arrival order.
  always @(posedge clk) begin : watch_rsp
    urib_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.read_data    = rsp_ch.read_data;
      got.tx_valid     = rsp_ch.tx_valid;
      got.tx_byte      = rsp_ch.tx_byte;
      got.irq          = rsp_ch.irq;
      got.access_error = rsp_ch.access_error;
      got.rx_ready     = rsp_ch.rx_ready;
      sb.check_result(got, $realtime);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
